>>> rtl/lpbg_pkg.sv
// Shared types and constants for the LED pulse burst generator.
package lpbg_pkg;

  // Register reset values
  localparam logic [31:0] PULSE_WIDTH_RST  = 32'd50;
  localparam logic [31:0] PULSE_PERIOD_RST = 32'd1000;
  localparam logic [7:0]  PULSES_RST       = 8'd1;
  localparam logic [31:0] BURST_GAP_RST    = 32'd0;
  localparam logic [7:0]  PIN_SELECT_RST   = 8'd0;

  // Register index codes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_SELECT   = 3'd4;

  typedef struct packed {
    logic [31:0] pulse_width_ms;
    logic [31:0] pulse_period_ms;
    logic [7:0]  pulses_per_burst;
    logic [31:0] burst_gap_ms;
    logic [7:0]  pin_select;
  } lpbg_cfg_t;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
  } lpbg_in_t;

  typedef struct packed {
    logic        led_level;
    logic [31:0] bursts_done;
    logic        fault;
  } lpbg_out_t;

endpackage

>>> rtl/lpbg_cfg.sv
// Configuration register file of the LED pulse burst generator.
module lpbg_cfg import lpbg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]          wr_data,
  output lpbg_cfg_t            cfg
);

  lpbg_cfg_t cfg_r;

  // Decode the register index and store the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_width_ms   <= PULSE_WIDTH_RST;
      cfg_r.pulse_period_ms  <= PULSE_PERIOD_RST;
      cfg_r.pulses_per_burst <= PULSES_RST;
      cfg_r.burst_gap_ms     <= BURST_GAP_RST;
      cfg_r.pin_select       <= PIN_SELECT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PULSE_WIDTH:  cfg_r.pulse_width_ms   <= wr_data;
        REG_PULSE_PERIOD: cfg_r.pulse_period_ms  <= wr_data;
        REG_PULSES:       cfg_r.pulses_per_burst <= wr_data[7:0];
        REG_BURST_GAP:    cfg_r.burst_gap_ms     <= wr_data;
        REG_PIN_SELECT:   cfg_r.pin_select       <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/lpbg_core.sv
// Burst sequencer: phase state, timing compare and result forming.
module lpbg_core import lpbg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  lpbg_in_t  item,
  input  lpbg_cfg_t cfg,
  output lpbg_out_t result
);

  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_SET_HIGH = 3'd1;
  localparam logic [2:0] PH_HIGH     = 3'd2;
  localparam logic [2:0] PH_LOW      = 3'd3;
  localparam logic [2:0] PH_WAIT     = 3'd4;
  localparam logic [2:0] PH_FAULT    = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] start_r, start_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [31:0] completed_r, completed_nxt;
  logic        led_r, led_nxt;

  logic [31:0] elapsed;
  logic [31:0] offset;
  logic [39:0] product;
  logic [31:0] thresh;
  logic        reached;
  logic [7:0]  index_inc;

  // Form elapsed time and the threshold for the current phase
  always_comb begin
    elapsed = item.now_ms - start_r;
    case (phase_r)
      PH_HIGH: offset = cfg.pulse_width_ms;
      PH_LOW:  offset = cfg.pulse_period_ms;
      default: offset = cfg.burst_gap_ms;
    endcase
    product   = {32'd0, index_r} * {8'd0, cfg.pulse_period_ms};
    thresh    = product[31:0] + offset;
    reached   = (elapsed >= thresh);
    index_inc = index_r + 8'd1;
  end

  // Take at most one phase step per poll beat
  always_comb begin
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    index_nxt     = index_r;
    completed_nxt = completed_r;
    led_nxt       = led_r;
    if (item.action) begin
      led_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_START: begin
          phase_nxt = (cfg.pin_select == 8'd0) ? PH_FAULT : PH_SET_HIGH;
        end
        PH_SET_HIGH: begin
          led_nxt = (cfg.pulse_width_ms != 32'd0);
          if (index_r == 8'd0) start_nxt = item.now_ms;
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          if (reached) begin
            led_nxt   = 1'b0;
            phase_nxt = PH_LOW;
          end
        end
        PH_LOW: begin
          if (reached) begin
            index_nxt = index_inc;
            phase_nxt = (index_inc >= cfg.pulses_per_burst) ? PH_WAIT : PH_SET_HIGH;
          end
        end
        PH_WAIT: begin
          if (reached) begin
            index_nxt     = 8'd0;
            completed_nxt = completed_r + 32'd1;
            phase_nxt     = PH_SET_HIGH;
          end
        end
        default: ;
      endcase
    end
  end

  // Advance the state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      start_r     <= 32'd0;
      index_r     <= 8'd0;
      completed_r <= 32'd0;
      led_r       <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      index_r     <= index_nxt;
      completed_r <= completed_nxt;
      led_r       <= led_nxt;
    end
  end

  assign result.led_level   = led_nxt;
  assign result.bursts_done = completed_nxt;
  assign result.fault       = (phase_nxt == PH_FAULT);

  // Fault is sticky until reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FAULT |=> phase_r == PH_FAULT)
    else $error("fault phase left");

  // Shutdown always drops the LED
  a_shutdown_off: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.action |=> !led_r)
    else $error("LED on after shutdown");

  // Burst count moves only out of the burst wait phase
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!fire || item.action || phase_r != PH_WAIT) |=> completed_r == $past(completed_r))
    else $error("burst count changed outside burst wait");

  // LED never turns on while faulted
  a_fault_dark: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FAULT |-> !led_r)
    else $error("LED on in fault phase");

endmodule

>>> rtl/led_pulse_burst_generator_top.sv
// Top level of the LED pulse burst generator: beat registers around the sequencer.
// Each in_data beat is a poll (action 0) carrying the millisecond time, or a
// shutdown (action 1) that drops the LED; every beat yields one out_data beat
// with the LED level, the completed burst count and a sticky fault flag. A
// beat is held in the input register and leaves through the result register;
// a new beat is taken every cycle unless out_stall holds a full result
// register; the throughput is set by the single pass through the sequencer's one 8x32
// multiply, add and compare, whose state updates as each beat moves to the
// result register. in_stall rises only while the result register is full and
// out_stall is high. Configuration writes are always taken (cfg_ready is high)
// and should only be made while no beat is in flight.
module led_pulse_burst_generator_top import lpbg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lpbg_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lpbg_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  lpbg_cfg_t cfg;
  lpbg_in_t  item_r;
  logic      item_vld_r;
  lpbg_out_t res_r;
  logic      res_vld_r;
  lpbg_out_t result;
  logic      advance;
  logic      in_fire;

  assign cfg_ready = 1'b1;

  lpbg_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move a beat to the result register when it is free or being taken
  assign advance  = item_vld_r && (!res_vld_r || !out_stall);
  assign in_stall = item_vld_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  lpbg_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Hold the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_fire) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_data;
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (!out_stall) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= result;
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule
